>>> sv/mfmd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mfmd_pkg: shared types, constants and helpers
// Value width, divider pipeline sizing and the divider stage payload.
// ---------------------------------------------------------------------------
package mfmd_pkg;

  localparam int VW         = 32;
  localparam int IO_W       = 32;
  localparam int DEN_W      = 31;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = (VW + DIV_BITS - 1) / DIV_BITS;
  localparam int PADW       = DIV_STAGES * DIV_BITS;

  typedef logic signed [VW-1:0]   val_t;
  typedef logic signed [2*VW:0]   wide_t;

  typedef struct packed {
    logic            valid;
    logic            neg;
    logic            ov;
    logic [VW-1:0]   pd;
    logic [VW-1:0]   rem;
    logic [PADW-1:0] dvd;
    logic [PADW-1:0] quo;
  } div_t;

  // True when a wide intermediate fits VW signed bits
  function automatic logic fits_wide(input wide_t v);
    logic [2*VW-VW+1:0] top;
    top = v[2*VW:VW-1];
    return (&top) | ~(|top);
  endfunction

  // True when a port word fits VW signed bits
  function automatic logic fits_io(input logic [IO_W-1:0] v);
    logic [IO_W-VW:0] top;
    top = v[IO_W-1:VW-1];
    return (&top) | ~(|top);
  endfunction

  // Force a value that is not positive to one
  function automatic val_t pos_or_one(input val_t v);
    return (v > 0) ? v : val_t'(1);
  endfunction

endpackage
`default_nettype wire

>>> sv/mfmd_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mfmd_in_if / mfmd_out_if: operand and result channels
// Valid/ready channels carrying the operand pair and the proper result.
// ---------------------------------------------------------------------------
interface mfmd_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [31:0] left_whole;
  logic signed [31:0] left_num;
  logic [30:0]        left_den;
  logic signed [31:0] right_whole;
  logic signed [31:0] right_num;
  logic [30:0]        right_den;

  modport source (output valid, cmd, left_whole, left_num, left_den,
                  right_whole, right_num, right_den, input ready);
  modport sink   (input valid, cmd, left_whole, left_num, left_den,
                  right_whole, right_num, right_den, output ready);
endinterface

interface mfmd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_whole;
  logic signed [31:0] res_num;
  logic [30:0]        res_den;
  logic               overflow;

  modport source (output valid, res_whole, res_num, res_den, overflow, input ready);
  modport sink   (input valid, res_whole, res_num, res_den, overflow, output ready);
endinterface
`default_nettype wire

>>> sv/mfmd_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mfmd_front: improper forms and products
// Four stages: wrap inputs and whole*den, add numerators and invert,
// multiply, then wrap products and set up the divider.
// ---------------------------------------------------------------------------
module mfmd_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic         in_valid,
  input  wire logic         cmd,
  input  wire logic [31:0]  left_whole,
  input  wire logic [31:0]  left_num,
  input  wire logic [30:0]  left_den,
  input  wire logic [31:0]  right_whole,
  input  wire logic [31:0]  right_num,
  input  wire logic [30:0]  right_den,
  output mfmd_pkg::div_t    div_o
);
  import mfmd_pkg::*;

  logic                   v1_r, v2_r, v3_r;
  logic                   cmd1_r, ov1_r, ov2_r, ov3_r;
  val_t                   ln1_r, rn1_r, ld1_r, rd1_r;
  logic signed [2*VW-1:0] lp1_r, rp1_r;
  val_t                   limp2_r, rmul2_r, ld2_r, rden2_r;
  logic signed [2*VW-1:0] pn3_r, pd3_r;
  div_t                   d4_r;

  val_t                   lw, ln, ld, rw, rn, rd;
  logic [IO_W-1:0]        lde, rde;
  logic                   ov1_nxt, ov2_nxt, ov4_nxt;
  wide_t                  lsum, rsum;
  val_t                   limp, rimp, pn, pdw, pdf, mag;

  // Wrap the port words to the value width
  always_comb begin
    lde     = IO_W'({1'b0, left_den});
    rde     = IO_W'({1'b0, right_den});
    lw      = left_whole[VW-1:0];
    ln      = left_num[VW-1:0];
    ld      = pos_or_one(lde[VW-1:0]);
    rw      = right_whole[VW-1:0];
    rn      = right_num[VW-1:0];
    rd      = pos_or_one(rde[VW-1:0]);
    ov1_nxt = !fits_io(left_whole) || !fits_io(left_num) || !fits_io(lde) ||
              !fits_io(right_whole) || !fits_io(right_num) || !fits_io(rde);
  end

  // Improper numerators, wrapped
  always_comb begin
    lsum    = wide_t'(ln1_r) + wide_t'(lp1_r);
    rsum    = wide_t'(rn1_r) + wide_t'(rp1_r);
    limp    = lsum[VW-1:0];
    rimp    = rsum[VW-1:0];
    ov2_nxt = ov1_r || !fits_wide(lsum) || !fits_wide(rsum);
  end

  // Wrap the products and take the dividend magnitude
  always_comb begin
    pn      = pn3_r[VW-1:0];
    pdw     = pd3_r[VW-1:0];
    pdf     = pos_or_one(pdw);
    mag     = pn[VW-1] ? -pn : pn;
    ov4_nxt = ov3_r || !fits_wide(wide_t'(pn3_r)) || !fits_wide(wide_t'(pd3_r));
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      d4_r.valid <= 1'b0;
    end else if (en) begin
      v1_r       <= in_valid;
      v2_r       <= v1_r;
      v3_r       <= v2_r;
      d4_r.valid <= v3_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      cmd1_r  <= cmd;
      ov1_r   <= ov1_nxt;
      ln1_r   <= ln;
      rn1_r   <= rn;
      ld1_r   <= ld;
      rd1_r   <= rd;
      lp1_r   <= lw * ld;
      rp1_r   <= rw * rd;

      ov2_r   <= ov2_nxt;
      limp2_r <= limp;
      ld2_r   <= ld1_r;
      rmul2_r <= cmd1_r ? rd1_r : rimp;
      rden2_r <= cmd1_r ? pos_or_one(rimp) : rd1_r;

      ov3_r   <= ov2_r;
      pn3_r   <= limp2_r * rmul2_r;
      pd3_r   <= ld2_r * rden2_r;

      d4_r.neg <= pn[VW-1];
      d4_r.ov  <= ov4_nxt;
      d4_r.pd  <= pdf;
      d4_r.rem <= '0;
      d4_r.dvd <= PADW'(mag);
      d4_r.quo <= '0;
    end
  end

  always_comb begin
    div_o = d4_r;
  end

endmodule
`default_nettype wire

>>> sv/mfmd_div_stage.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mfmd_div_stage: one stage of the restoring divider
// Retires DIV_BITS quotient bits per stage, MSB first.
// ---------------------------------------------------------------------------
module mfmd_div_stage (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  mfmd_pkg::div_t d_i,
  output mfmd_pkg::div_t d_o
);
  import mfmd_pkg::*;

  div_t          d_r, d_nxt;
  logic [VW:0]   t;
  logic [VW-1:0] r;
  logic [PADW-1:0] d, q;
  logic          qb;

  // Shift, compare and subtract for each bit
  always_comb begin
    r = d_i.rem;
    d = d_i.dvd;
    q = d_i.quo;
    t = '0;
    qb = 1'b0;
    for (int i = 0; i < DIV_BITS; i++) begin
      t  = {r, d[PADW-1]};
      d  = {d[PADW-2:0], 1'b0};
      qb = (t >= {1'b0, d_i.pd});
      if (qb) begin
        t = t - {1'b0, d_i.pd};
      end
      r = t[VW-1:0];
      q = {q[PADW-2:0], qb};
    end
    d_nxt     = d_i;
    d_nxt.rem = r;
    d_nxt.dvd = d;
    d_nxt.quo = q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else if (en) begin
      d_r.valid <= d_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r.neg <= d_nxt.neg;
      d_r.ov  <= d_nxt.ov;
      d_r.pd  <= d_nxt.pd;
      d_r.rem <= d_nxt.rem;
      d_r.dvd <= d_nxt.dvd;
      d_r.quo <= d_nxt.quo;
    end
  end

  assign d_o = d_r;

endmodule
`default_nettype wire

>>> sv/mixed_fraction_mul_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mixed_fraction_mul_div: multiply or divide two mixed fractions
// Stages: 4 front stages, DIV_STAGES divider stages (8) and 1 output register.
// Throughput: one transaction per cycle; the whole pipe holds on a stall.
// The divider retires four quotient bits per stage and sets the depth.
// Reset clears the valid bits only; payload registers are not reset.
// ---------------------------------------------------------------------------
module mixed_fraction_mul_div (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mfmd_in_if.sink    in_if,
  mfmd_out_if.source out_if
);
  import mfmd_pkg::*;

  logic  en;
  div_t  chain [DIV_STAGES+1];
  val_t  qv, rv;
  logic  out_v_r;
  logic signed [31:0] whole_r, num_r;
  logic [30:0] den_r;
  logic  ov_r;

  // Advance the pipe whenever the output register can move
  assign en          = !out_v_r || out_if.ready;
  assign in_if.ready = en;

  mfmd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_if.valid),
    .cmd         (in_if.cmd),
    .left_whole  (in_if.left_whole),
    .left_num    (in_if.left_num),
    .left_den    (in_if.left_den),
    .right_whole (in_if.right_whole),
    .right_num   (in_if.right_num),
    .right_den   (in_if.right_den),
    .div_o       (chain[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    mfmd_div_stage u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_i   (chain[g]),
      .d_o   (chain[g+1])
    );
  end

  // Restore the sign of quotient and remainder
  always_comb begin
    qv = chain[DIV_STAGES].quo[VW-1:0];
    rv = chain[DIV_STAGES].rem;
    if (chain[DIV_STAGES].neg) begin
      qv = -qv;
      rv = -rv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= chain[DIV_STAGES].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      whole_r <= 32'(qv);
      num_r   <= 32'(rv);
      den_r   <= DEN_W'(chain[DIV_STAGES].pd);
      ov_r    <= chain[DIV_STAGES].ov;
    end
  end

  assign out_if.valid     = out_v_r;
  assign out_if.res_whole = whole_r;
  assign out_if.res_num   = num_r;
  assign out_if.res_den   = den_r;
  assign out_if.overflow  = ov_r;

endmodule
`default_nettype wire
